// ----- sv/plts_pkg.sv -----
// shared types and constants for the precedence level sorter
`timescale 1ns / 1ps
package plts_pkg;
	localparam int MAX_NODES = 32;
	localparam int NODE_W = 5;
	localparam int CNT_W = 6;
	localparam int LEVEL_W = 13;
	localparam logic [LEVEL_W-1:0] LEVEL_CAP = 13'd8191;
	localparam logic [1:0] FUNC_EDGE = 2'd0;
	localparam logic [1:0] FUNC_GROUP = 2'd1;
	localparam logic [1:0] FUNC_COMPUTE = 2'd2;
	localparam logic [0:0] REG_NODE_COUNT = 1'd0;
	localparam logic [0:0] REG_LEVEL_STEP = 1'd1;
endpackage

// ----- sv/plts_level_add.sv -----
// shared saturating level adder and max compare
`timescale 1ns / 1ps
module plts_level_add (
	input  logic [plts_pkg::LEVEL_W-1:0] base,
	input  logic [7:0]                   step,
	input  logic [plts_pkg::LEVEL_W-1:0] cur,
	input  logic                         cur_valid,
	output logic [plts_pkg::LEVEL_W-1:0] result
);
	import plts_pkg::*;
	logic [LEVEL_W:0] sum;
	logic [LEVEL_W-1:0] cand;
	always_comb begin
		sum = {1'b0, base} + {{(LEVEL_W-7){1'b0}}, step};
		cand = (sum > {1'b0, LEVEL_CAP}) ? LEVEL_CAP : sum[LEVEL_W-1:0];
		result = (!cur_valid || cand > cur) ? cand : cur;
	end
endmodule

// ----- sv/precedence_level_topo_sort.sv -----
// top level: kahn sort with longest path levels over a bit matrix
`timescale 1ns / 1ps
// Edge and group requests are taken one per cycle while the block is idle and
// give no result. A compute request runs a sequencer over the adjacency matrix
// with one shared adder and compare: it clears the in-degrees, counts them (one
// matrix bit a cycle), seeds the sources, then for each popped node pops it and
// relaxes its successors, makes one last pop that finds the queue empty, and
// then gives n results, each held until taken, n = node_count capped at 32.
// The block is not ready until the last result is taken. Node levels and the
// in-degree table sit in small register arrays read at one or two addresses a
// cycle.
module precedence_level_topo_sort (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [1:0]  func,
	input  logic [4:0]  node_a,
	input  logic [4:0]  node_b,
	input  logic        a_is_tighter,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  node_index,
	output logic        has_priority,
	output logic [12:0] priority_res,
	output logic        acyclic,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import plts_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CLR  = 3'd1;
	localparam logic [2:0] ST_CNT  = 3'd2;
	localparam logic [2:0] ST_SEED = 3'd3;
	localparam logic [2:0] ST_POP  = 3'd4;
	localparam logic [2:0] ST_RLX  = 3'd5;
	localparam logic [2:0] ST_EMIT = 3'd6;

	logic [MAX_NODES-1:0] edge_q [MAX_NODES];
	logic [NODE_W:0] group_q [MAX_NODES];
	logic [CNT_W-1:0] indeg_q [MAX_NODES];
	logic [LEVEL_W-1:0] level_q [MAX_NODES];
	logic [NODE_W-1:0] queue_q [MAX_NODES];
	logic [MAX_NODES-1:0] lvalid_q;
	logic [CNT_W-1:0] visited_q, head_q, tail_q, n_q;
	logic [5:0] node_count_q;
	logic [7:0] level_step_q;
	logic [2:0] state_q;
	logic [NODE_W-1:0] u_q, v_q;
	logic [LEVEL_W-1:0] base_q;
	logic out_valid_q;

	logic wr;
	logic [LEVEL_W-1:0] relaxed;
	logic [NODE_W-1:0] v_nx;
	logic v_end;
	logic [NODE_W-1:0] gsel;
	logic has_c;
	logic [LEVEL_W-1:0] lvl_c;

	// config port
	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	always_comb begin
		unique case (paddr[2])
			REG_NODE_COUNT: prdata = {26'd0, node_count_q};
			REG_LEVEL_STEP: prdata = {24'd0, level_step_q};
			default:        prdata = '0;
		endcase
	end

	assign ready = (state_q == ST_IDLE);
	assign v_nx = v_q + 5'd1;
	assign v_end = ({1'b0, v_q} + 6'd1 == n_q);

	plts_level_add u_add (
		.base(base_q), .step(level_step_q), .cur(level_q[v_q]),
		.cur_valid(lvalid_q[v_q]), .result(relaxed)
	);

	// result for node v_q: own level, else group level
	always_comb begin
		gsel = group_q[v_q][NODE_W-1:0];
		has_c = 1'b0;
		lvl_c = '0;
		if (lvalid_q[v_q]) begin
			has_c = 1'b1;
			lvl_c = level_q[v_q];
		end else if (group_q[v_q][NODE_W] && {1'b0, gsel} < n_q && lvalid_q[gsel]) begin
			has_c = 1'b1;
			lvl_c = level_q[gsel];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 6'd32;
			level_step_q <= 8'd10;
		end else if (wr) begin
			if (paddr[2] == REG_NODE_COUNT) node_count_q <= pwdata[5:0];
			else level_step_q <= pwdata[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_NODES; i++) begin
				edge_q[i] <= '0;
				group_q[i] <= '0;
			end
			lvalid_q <= '0;
			visited_q <= '0;
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			head_q <= '0;
			tail_q <= '0;
			n_q <= '0;
			u_q <= '0;
			v_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (valid) begin
						unique case (func)
							FUNC_EDGE: begin
								if (a_is_tighter) edge_q[node_b][node_a] <= 1'b1;
								else edge_q[node_a][node_b] <= 1'b1;
							end
							FUNC_GROUP: group_q[node_a] <= {1'b1, node_b};
							FUNC_COMPUTE: begin
								n_q <= (node_count_q > 6'd32) ? 6'd32 : node_count_q;
								lvalid_q <= '0;
								v_q <= '0;
								u_q <= '0;
								head_q <= '0;
								tail_q <= '0;
								visited_q <= '0;
								state_q <= (node_count_q == 6'd0) ? ST_IDLE : ST_CLR;
							end
							default: ;
						endcase
					end
				end
				ST_CLR: begin
					indeg_q[v_q] <= '0;
					v_q <= v_nx;
					if (v_end) begin
						v_q <= '0;
						state_q <= ST_CNT;
					end
				end
				ST_CNT: begin
					// one matrix bit a cycle: row u_q, column v_q
					if (edge_q[u_q][v_q]) indeg_q[v_q] <= indeg_q[v_q] + 6'd1;
					v_q <= v_nx;
					if (v_end) begin
						v_q <= '0;
						u_q <= u_q + 5'd1;
						if ({1'b0, u_q} + 6'd1 == n_q) state_q <= ST_SEED;
					end
				end
				ST_SEED: begin
					if (indeg_q[v_q] == '0) begin
						queue_q[tail_q[NODE_W-1:0]] <= v_q;
						tail_q <= tail_q + 6'd1;
						level_q[v_q] <= '0;
						lvalid_q[v_q] <= 1'b1;
					end
					v_q <= v_nx;
					if (v_end) begin
						v_q <= '0;
						state_q <= ST_POP;
					end
				end
				ST_POP: begin
					if (head_q == tail_q) begin
						v_q <= '0;
						state_q <= ST_EMIT;
						out_valid_q <= 1'b1;
					end else begin
						u_q <= queue_q[head_q[NODE_W-1:0]];
						base_q <= level_q[queue_q[head_q[NODE_W-1:0]]];
						head_q <= head_q + 6'd1;
						visited_q <= visited_q + 6'd1;
						v_q <= '0;
						state_q <= ST_RLX;
					end
				end
				ST_RLX: begin
					if (edge_q[u_q][v_q]) begin
						level_q[v_q] <= relaxed;
						lvalid_q[v_q] <= 1'b1;
						if (indeg_q[v_q] != '0) begin
							indeg_q[v_q] <= indeg_q[v_q] - 6'd1;
							if (indeg_q[v_q] == 6'd1 && tail_q < 6'd32) begin
								queue_q[tail_q[NODE_W-1:0]] <= v_q;
								tail_q <= tail_q + 6'd1;
							end
						end
					end
					v_q <= v_nx;
					if (v_end) state_q <= ST_POP;
				end
				ST_EMIT: begin
					if (out_ready) begin
						v_q <= v_nx;
						if (v_end) begin
							out_valid_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result fields come straight from the node tables while emitting
	assign out_valid = out_valid_q;
	assign node_index = v_q;
	assign has_priority = has_c;
	assign priority_res = lvl_c;
	assign acyclic = (visited_q == n_q);
	assign last = v_end;
endmodule
